// ===== sv/clpg_pkg.sv =====
package clpg_pkg;

    localparam int SCREEN_WIDTH  = 96;
    localparam int SCREEN_HEIGHT = 64;
    localparam int COORD_BITS    = 11;

    localparam int DELTA_W = COORD_BITS + 1;
    localparam int STEP_W  = 25;
    localparam int NUM_W   = 37;
    localparam int DIVN_W  = 35;
    localparam int DIVD_W  = 12;
    localparam int DCNT_W  = 6;
    localparam int MULA_W  = 25;
    localparam int MULB_W  = 13;
    localparam int MULP_W  = MULA_W + MULB_W;
    localparam int ERR_W   = 14;
    localparam int COLOR_W = 16;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [DELTA_W-1:0]    delta_t;
    typedef logic        [COORD_BITS-1:0] mag_t;
    typedef logic        [DIVD_W-1:0]     span_t;
    typedef logic signed [STEP_W-1:0]     step_t;
    typedef logic signed [NUM_W-1:0]      num_t;
    typedef logic signed [ERR_W-1:0]      err_t;
    typedef logic        [COLOR_W-1:0]    color_t;
    typedef logic        [DIVN_W-1:0]     divn_t;
    typedef logic        [DIVD_W-1:0]     divd_t;
    typedef logic        [DCNT_W-1:0]     dcnt_t;
    typedef logic signed [MULA_W-1:0]     mula_t;
    typedef logic signed [MULB_W-1:0]     mulb_t;
    typedef logic signed [MULP_W-1:0]     mulp_t;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    typedef enum logic [1:0] {
        OP_CLIP,
        OP_AIM,
        OP_FINAL
    } op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_CLIP,
        S_MUL1,
        S_DIV1_GO,
        S_DIV1_WAIT,
        S_MUL2,
        S_DIV2_GO,
        S_DIV2_WAIT,
        S_MUL3,
        S_DIV3_GO,
        S_DIV3_WAIT,
        S_COMMIT,
        S_REJECT
    } state_t;

    typedef struct packed {
        logic capture;
        logic tick;
        logic mul_en;
        logic div_go;
        op_t  op;
        logic side;
        logic store_res0;
        logic store_div;
        logic commit;
        logic reject;
    } cmd_t;

    typedef struct packed {
        logic degen;
        logic other_zero;
        logic in_range;
        logic div_busy;
        logic out_busy;
    } status_t;

endpackage

// ===== sv/clpg_div.sv =====
module clpg_div
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    go,
    input  clpg_pkg::divn_t         dividend,
    input  clpg_pkg::divd_t         divisor,
    output logic                    busy,
    output clpg_pkg::divn_t         quotient,
    output clpg_pkg::divd_t         remainder
);

    logic            busy_reg, busy_next;
    clpg_pkg::dcnt_t cnt_reg, cnt_next;
    clpg_pkg::divn_t quo_reg, quo_next;
    clpg_pkg::divd_t rem_reg, rem_next;
    clpg_pkg::divd_t dsr_reg, dsr_next;

    logic [clpg_pkg::DIVD_W:0] rem_sh;
    logic                      ge;

    always_comb
    begin
        rem_sh    = {rem_reg, quo_reg[clpg_pkg::DIVN_W-1]};
        ge        = rem_sh >= {1'b0, dsr_reg};
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (go)
        begin
            busy_next = 1'b1;
            cnt_next  = clpg_pkg::dcnt_t'(clpg_pkg::DIVN_W);
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[clpg_pkg::DIVN_W-2:0], ge};
            rem_next = ge ? clpg_pkg::divd_t'(rem_sh - {1'b0, dsr_reg})
                          : clpg_pkg::divd_t'(rem_sh);
            cnt_next = cnt_reg - clpg_pkg::dcnt_t'(1);
            if (cnt_reg == clpg_pkg::dcnt_t'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign busy      = busy_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// ===== sv/clpg_ctrl.sv =====
module clpg_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic               s_tuser,
    input  clpg_pkg::status_t  status,
    output clpg_pkg::cmd_t     cmd
);

    clpg_pkg::state_t state_reg, state_next;
    logic             side_reg, side_next;
    logic             accept;

    assign s_tready = (state_reg == clpg_pkg::S_IDLE) && !status.out_busy;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        state_next = state_reg;
        side_next  = side_reg;
        case (state_reg)
            clpg_pkg::S_IDLE:
            begin
                if (accept && s_tuser == clpg_pkg::CMD_START)
                begin
                    state_next = clpg_pkg::S_CHECK;
                    side_next  = 1'b0;
                end
            end
            clpg_pkg::S_CHECK:
            begin
                state_next = status.degen ? clpg_pkg::S_REJECT : clpg_pkg::S_CLIP;
            end
            clpg_pkg::S_CLIP:
            begin
                if (status.other_zero)
                begin
                    state_next = side_reg ? clpg_pkg::S_MUL3 : clpg_pkg::S_CLIP;
                    side_next  = 1'b1;
                end
                else
                begin
                    state_next = clpg_pkg::S_MUL1;
                end
            end
            clpg_pkg::S_MUL1:    state_next = clpg_pkg::S_DIV1_GO;
            clpg_pkg::S_DIV1_GO: state_next = clpg_pkg::S_DIV1_WAIT;
            clpg_pkg::S_DIV1_WAIT:
            begin
                if (!status.div_busy)
                begin
                    if (status.in_range)
                    begin
                        state_next = side_reg ? clpg_pkg::S_MUL3 : clpg_pkg::S_CLIP;
                        side_next  = 1'b1;
                    end
                    else
                    begin
                        state_next = clpg_pkg::S_MUL2;
                    end
                end
            end
            clpg_pkg::S_MUL2:    state_next = clpg_pkg::S_DIV2_GO;
            clpg_pkg::S_DIV2_GO: state_next = clpg_pkg::S_DIV2_WAIT;
            clpg_pkg::S_DIV2_WAIT:
            begin
                if (!status.div_busy)
                begin
                    state_next = side_reg ? clpg_pkg::S_MUL3 : clpg_pkg::S_CLIP;
                    side_next  = 1'b1;
                end
            end
            clpg_pkg::S_MUL3:    state_next = clpg_pkg::S_DIV3_GO;
            clpg_pkg::S_DIV3_GO: state_next = clpg_pkg::S_DIV3_WAIT;
            clpg_pkg::S_DIV3_WAIT:
            begin
                if (!status.div_busy)
                begin
                    state_next = clpg_pkg::S_COMMIT;
                end
            end
            clpg_pkg::S_COMMIT,
            clpg_pkg::S_REJECT:
            begin
                if (!status.out_busy)
                begin
                    state_next = clpg_pkg::S_IDLE;
                end
            end
            default: state_next = clpg_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        cmd.op   = clpg_pkg::OP_CLIP;
        cmd.side = side_reg;
        case (state_reg)
            clpg_pkg::S_IDLE:
            begin
                cmd.tick    = accept && s_tuser == clpg_pkg::CMD_TICK;
                cmd.capture = accept && s_tuser == clpg_pkg::CMD_START;
            end
            clpg_pkg::S_CLIP:      cmd.store_res0 = status.other_zero;
            clpg_pkg::S_MUL1:      cmd.mul_en = 1'b1;
            clpg_pkg::S_DIV1_GO:   cmd.div_go = 1'b1;
            clpg_pkg::S_DIV1_WAIT: cmd.store_res0 = !status.div_busy && status.in_range;
            clpg_pkg::S_MUL2:
            begin
                cmd.op     = clpg_pkg::OP_AIM;
                cmd.mul_en = 1'b1;
            end
            clpg_pkg::S_DIV2_GO:
            begin
                cmd.op     = clpg_pkg::OP_AIM;
                cmd.div_go = 1'b1;
            end
            clpg_pkg::S_DIV2_WAIT:
            begin
                cmd.op        = clpg_pkg::OP_AIM;
                cmd.store_div = !status.div_busy;
            end
            clpg_pkg::S_MUL3:
            begin
                cmd.op     = clpg_pkg::OP_FINAL;
                cmd.mul_en = 1'b1;
            end
            clpg_pkg::S_DIV3_GO:
            begin
                cmd.op     = clpg_pkg::OP_FINAL;
                cmd.div_go = 1'b1;
            end
            clpg_pkg::S_DIV3_WAIT: cmd.op = clpg_pkg::OP_FINAL;
            clpg_pkg::S_COMMIT:
            begin
                cmd.op     = clpg_pkg::OP_FINAL;
                cmd.commit = !status.out_busy;
            end
            clpg_pkg::S_REJECT:    cmd.reject = !status.out_busy;
            default:               cmd.op = clpg_pkg::OP_CLIP;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= clpg_pkg::S_IDLE;
            side_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            side_reg  <= side_next;
        end
    end

endmodule

// ===== sv/clpg_datapath.sv =====
module clpg_datapath
(
    input  logic               clk,
    input  logic               rst_n,
    input  clpg_pkg::cmd_t     cmd,
    output clpg_pkg::status_t  status,
    input  logic [63:0]        s_tdata,
    input  logic               m_tready,
    output logic               m_tvalid,
    output logic [39:0]        m_tdata,
    output logic [1:0]         m_tuser,
    output logic               m_tlast
);

    // captured start transaction
    clpg_pkg::coord_t sx_reg, sy_reg, ex_reg, ey_reg;
    clpg_pkg::color_t col_in_reg;

    // clip working registers
    clpg_pkg::num_t   num_reg;
    clpg_pkg::step_t  first_reg, fin_reg;

    // line state
    logic             active_reg, active_next;
    logic             major_x_reg, major_x_next;
    clpg_pkg::coord_t cur_x_reg, cur_x_next;
    clpg_pkg::coord_t cur_y_reg, cur_y_next;
    clpg_pkg::err_t   err_reg, err_next;
    clpg_pkg::span_t  ms2_reg, ms2_next;
    clpg_pkg::span_t  mn2_reg, mn2_next;
    logic             major_neg_reg, major_neg_next;
    logic             minor_neg_reg, minor_neg_next;
    clpg_pkg::step_t  idx_reg, idx_next;
    clpg_pkg::step_t  last_reg, last_next;
    clpg_pkg::color_t color_reg, color_next;

    // output register
    logic             ov_reg, ov_next;
    logic             opv_reg, opv_next;
    clpg_pkg::coord_t ox_reg, ox_next;
    clpg_pkg::coord_t oy_reg, oy_next;
    clpg_pkg::color_t oc_reg, oc_next;
    logic             olast_reg, olast_next;
    logic             orej_reg, orej_next;

    clpg_pkg::delta_t cx, cy, bd, od, other_d, lim, lim_o, res0, aim, bc;
    clpg_pkg::mag_t   acx, acy, ab, ao;
    logic             xm;
    clpg_pkg::coord_t base_co, cross_co, s_major, s_minor;
    clpg_pkg::mula_t  ma;
    clpg_pkg::mulb_t  mb;
    clpg_pkg::mulp_t  mp;
    clpg_pkg::num_t   num_next;
    clpg_pkg::divn_t  div_n, div_q;
    clpg_pkg::divd_t  div_d, div_r;
    logic             div_busy;
    logic             num_neg, q_neg;
    clpg_pkg::step_t  qm, qs, t, res_div, clip_res, off;
    logic             step_end, carry;
    logic signed [clpg_pkg::ERR_W:0] err_sum;

    assign cx  = clpg_pkg::delta_t'(ex_reg) - clpg_pkg::delta_t'(sx_reg);
    assign cy  = clpg_pkg::delta_t'(ey_reg) - clpg_pkg::delta_t'(sy_reg);
    assign acx = clpg_pkg::mag_t'(cx < 0 ? -cx : cx);
    assign acy = clpg_pkg::mag_t'(cy < 0 ? -cy : cy);
    assign xm  = acx > acy;
    assign bd  = xm ? cx : cy;
    assign od  = xm ? cy : cx;
    assign ab  = xm ? acx : acy;
    assign ao  = xm ? acy : acx;

    assign base_co  = cmd.side ? (xm ? ex_reg : ey_reg) : (xm ? sx_reg : sy_reg);
    assign cross_co = cmd.side ? (xm ? ey_reg : ex_reg) : (xm ? sy_reg : sx_reg);
    assign s_major  = xm ? sx_reg : sy_reg;
    assign s_minor  = xm ? sy_reg : sx_reg;
    assign other_d  = cmd.side ? -od : od;
    assign lim      = xm ? clpg_pkg::delta_t'(clpg_pkg::SCREEN_WIDTH)
                         : clpg_pkg::delta_t'(clpg_pkg::SCREEN_HEIGHT);
    assign lim_o    = xm ? clpg_pkg::delta_t'(clpg_pkg::SCREEN_HEIGHT)
                         : clpg_pkg::delta_t'(clpg_pkg::SCREEN_WIDTH);
    assign bc       = clpg_pkg::delta_t'(base_co);

    // clip offset when the endpoint itself is off screen
    always_comb
    begin
        if (bc < 0)
        begin
            res0 = -bc;
        end
        else if (bc >= lim)
        begin
            res0 = bc - lim + clpg_pkg::delta_t'(1);
        end
        else
        begin
            res0 = '0;
        end
    end

    // shared multiplier, result doubled and biased by the major span
    always_comb
    begin
        case (cmd.op)
            clpg_pkg::OP_AIM:
            begin
                ma = clpg_pkg::mula_t'(aim);
                mb = clpg_pkg::mulb_t'(ab);
            end
            clpg_pkg::OP_FINAL:
            begin
                ma = clpg_pkg::mula_t'(first_reg);
                mb = clpg_pkg::mulb_t'(ao);
            end
            default:
            begin
                ma = clpg_pkg::mula_t'(res0);
                mb = clpg_pkg::mulb_t'(other_d);
            end
        endcase
        mp = ma * mb;
        if (cmd.op == clpg_pkg::OP_AIM)
        begin
            num_next = (clpg_pkg::num_t'(mp) <<< 1) - clpg_pkg::num_t'(ab);
        end
        else
        begin
            num_next = (clpg_pkg::num_t'(mp) <<< 1) + clpg_pkg::num_t'(ab);
        end
    end

    assign num_neg = num_reg < 0;
    assign div_n   = clpg_pkg::divn_t'(num_neg ? -num_reg : num_reg);
    assign div_d   = (cmd.op == clpg_pkg::OP_AIM) ? {ao, 1'b0} : {ab, 1'b0};

    clpg_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .go        (cmd.div_go),
        .dividend  (div_n),
        .divisor   (div_d),
        .busy      (div_busy),
        .quotient  (div_q),
        .remainder (div_r)
    );

    // signed truncating quotient
    always_comb
    begin
        case (cmd.op)
            // the aim multiply still reads the first quotient
            clpg_pkg::OP_AIM:   q_neg = cmd.mul_en ? num_neg ^ (bd < 0) : num_neg;
            clpg_pkg::OP_FINAL: q_neg = num_neg ^ (od < 0);
            default:            q_neg = num_neg ^ (bd < 0);
        endcase
        qm = clpg_pkg::step_t'(div_q);
        qs = q_neg ? -qm : qm;
    end

    assign t   = clpg_pkg::step_t'(cross_co) + qs;
    assign aim = (t < 0) ? -clpg_pkg::delta_t'(cross_co)
                         : clpg_pkg::delta_t'(cross_co) - lim_o + clpg_pkg::delta_t'(1);
    assign res_div  = qs + ((cmd.side || div_r != '0) ? clpg_pkg::step_t'(1)
                                                      : clpg_pkg::step_t'(0));
    assign clip_res = cmd.store_res0 ? clpg_pkg::step_t'(res0) : res_div;
    assign off      = (bd < 0) ? -first_reg : first_reg;

    assign status.degen      = (sx_reg == ex_reg) && (sy_reg == ey_reg);
    assign status.other_zero = od == '0;
    assign status.in_range   = (t >= 0) && (t < clpg_pkg::step_t'(lim_o));
    assign status.div_busy   = div_busy;
    assign status.out_busy   = ov_reg && !m_tready;

    // line state and output register
    always_comb
    begin
        active_next    = active_reg;
        major_x_next   = major_x_reg;
        cur_x_next     = cur_x_reg;
        cur_y_next     = cur_y_reg;
        err_next       = err_reg;
        ms2_next       = ms2_reg;
        mn2_next       = mn2_reg;
        major_neg_next = major_neg_reg;
        minor_neg_next = minor_neg_reg;
        idx_next       = idx_reg;
        last_next      = last_reg;
        color_next     = color_reg;
        ov_next        = ov_reg && !m_tready;
        opv_next       = opv_reg;
        ox_next        = ox_reg;
        oy_next        = oy_reg;
        oc_next        = oc_reg;
        olast_next     = olast_reg;
        orej_next      = orej_reg;

        step_end = idx_reg >= last_reg;
        err_sum  = (clpg_pkg::ERR_W + 1)'(err_reg)
                 + (clpg_pkg::ERR_W + 1)'($signed({1'b0, mn2_reg}));
        carry    = err_sum >= (clpg_pkg::ERR_W + 1)'($signed({1'b0, ms2_reg}));

        if (cmd.tick)
        begin
            ov_next    = 1'b1;
            orej_next  = 1'b0;
            opv_next   = active_reg;
            ox_next    = active_reg ? cur_x_reg : '0;
            oy_next    = active_reg ? cur_y_reg : '0;
            oc_next    = active_reg ? color_reg : '0;
            olast_next = active_reg && step_end;
            if (active_reg)
            begin
                err_next = carry
                    ? clpg_pkg::err_t'(err_sum
                        - (clpg_pkg::ERR_W + 1)'($signed({1'b0, ms2_reg})))
                    : clpg_pkg::err_t'(err_sum);
                if (major_x_reg)
                begin
                    cur_x_next = major_neg_reg ? cur_x_reg - clpg_pkg::coord_t'(1)
                                               : cur_x_reg + clpg_pkg::coord_t'(1);
                    if (carry)
                    begin
                        cur_y_next = minor_neg_reg ? cur_y_reg - clpg_pkg::coord_t'(1)
                                                   : cur_y_reg + clpg_pkg::coord_t'(1);
                    end
                end
                else
                begin
                    cur_y_next = major_neg_reg ? cur_y_reg - clpg_pkg::coord_t'(1)
                                               : cur_y_reg + clpg_pkg::coord_t'(1);
                    if (carry)
                    begin
                        cur_x_next = minor_neg_reg ? cur_x_reg - clpg_pkg::coord_t'(1)
                                                   : cur_x_reg + clpg_pkg::coord_t'(1);
                    end
                end
                if (step_end)
                begin
                    active_next = 1'b0;
                end
                else
                begin
                    idx_next = idx_reg + clpg_pkg::step_t'(1);
                end
            end
        end

        if (cmd.reject)
        begin
            active_next = 1'b0;
            ov_next     = 1'b1;
            opv_next    = 1'b0;
            ox_next     = '0;
            oy_next     = '0;
            oc_next     = '0;
            olast_next  = 1'b0;
            orej_next   = 1'b1;
        end

        if (cmd.commit)
        begin
            major_x_next   = xm;
            ms2_next       = {ab, 1'b0};
            mn2_next       = {ao, 1'b0};
            major_neg_next = bd < 0;
            minor_neg_next = od < 0;
            if (xm)
            begin
                cur_x_next = clpg_pkg::coord_t'(clpg_pkg::step_t'(s_major) + off);
                cur_y_next = clpg_pkg::coord_t'(clpg_pkg::step_t'(s_minor) + qs);
            end
            else
            begin
                cur_y_next = clpg_pkg::coord_t'(clpg_pkg::step_t'(s_major) + off);
                cur_x_next = clpg_pkg::coord_t'(clpg_pkg::step_t'(s_minor) + qs);
            end
            err_next    = num_neg ? -clpg_pkg::err_t'(div_r) : clpg_pkg::err_t'(div_r);
            idx_next    = first_reg;
            last_next   = fin_reg;
            active_next = first_reg <= fin_reg;
            color_next  = col_in_reg;
            ov_next     = 1'b1;
            opv_next    = 1'b0;
            ox_next     = '0;
            oy_next     = '0;
            oc_next     = '0;
            olast_next  = 1'b0;
            orej_next   = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            sx_reg     <= clpg_pkg::coord_t'(s_tdata[10:0]);
            sy_reg     <= clpg_pkg::coord_t'(s_tdata[21:11]);
            ex_reg     <= clpg_pkg::coord_t'(s_tdata[32:22]);
            ey_reg     <= clpg_pkg::coord_t'(s_tdata[43:33]);
            col_in_reg <= s_tdata[59:44];
        end
        if (cmd.mul_en)
        begin
            num_reg <= num_next;
        end
        if ((cmd.store_res0 || cmd.store_div) && !cmd.side)
        begin
            first_reg <= clip_res;
        end
        if ((cmd.store_res0 || cmd.store_div) && cmd.side)
        begin
            fin_reg <= clpg_pkg::step_t'(ab) - clip_res;
        end
        opv_reg   <= opv_next;
        ox_reg    <= ox_next;
        oy_reg    <= oy_next;
        oc_reg    <= oc_next;
        olast_reg <= olast_next;
        orej_reg  <= orej_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            major_x_reg   <= 1'b0;
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
            err_reg       <= '0;
            ms2_reg       <= '0;
            mn2_reg       <= '0;
            major_neg_reg <= 1'b0;
            minor_neg_reg <= 1'b0;
            idx_reg       <= '0;
            last_reg      <= '0;
            color_reg     <= '0;
            ov_reg        <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            major_x_reg   <= major_x_next;
            cur_x_reg     <= cur_x_next;
            cur_y_reg     <= cur_y_next;
            err_reg       <= err_next;
            ms2_reg       <= ms2_next;
            mn2_reg       <= mn2_next;
            major_neg_reg <= major_neg_next;
            minor_neg_reg <= minor_neg_next;
            idx_reg       <= idx_next;
            last_reg      <= last_next;
            color_reg     <= color_next;
            ov_reg        <= ov_next;
        end
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = {2'b00, oc_reg, oy_reg, ox_reg};
    assign m_tuser  = {orej_reg, opv_reg};
    assign m_tlast  = olast_reg;

endmodule

// ===== sv/clipped_line_pixel_generator_top.sv =====
// channel | dir | signals                          | contents
// s       | in  | s_tvalid s_tready s_tdata s_tuser | tuser: 0 start, 1 tick; tdata: endpoints, colour
// m       | out | m_tvalid m_tready m_tdata m_tuser | tdata: pixel x, y, colour; tuser: valid, rejected
//         |     | m_tlast                          | last pixel of the line
// ticks stream back to back while m_tready is high
// a rejected start runs no division, any other start runs one to five divisions
// on the shared 35-step divider
// rst_n is asynchronous and active low; it drops any line in progress
// a held result on m stalls further input until it is taken
module clipped_line_pixel_generator_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // x_start, y_start, x_end, y_end, draw_color
    input  logic        s_tuser,   // cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // pixel_x, pixel_y, pixel_color
    output logic [1:0]  m_tuser,   // pixel_valid, rejected
    output logic        m_tlast
);

    clpg_pkg::cmd_t    cmd;
    clpg_pkg::status_t status;

    clpg_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .status   (status),
        .cmd      (cmd)
    );

    clpg_datapath u_datapath
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .status   (status),
        .s_tdata  (s_tdata),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
